[hdl/integer_to_ascii_radix_converter_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the integer-to-ASCII radix converter
// Clocked on clk; all but the reset macro are disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_CONVERTER_UNIT_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ITOA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("itoa assertion failed");

// Next-cycle implication.
`define ITOA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("itoa assertion failed");

// Next-cycle implication that also holds across reset.
`define ITOA_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("itoa reset assertion failed");

`endif

[hdl/itoa_pkg.sv]
// ---------------------------------------------------------------------------
// itoa_pkg
// Shared constants and the digit-to-ASCII mapping of the radix converter.
// ---------------------------------------------------------------------------
package itoa_pkg;

  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  // Word index of the radix register (paddr bit 2).
  localparam logic REG_RADIX = 1'b0;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;  // '-'
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;  // '9'
  localparam logic [CHAR_W-1:0] CHAR_Z     = 7'h5A;  // 'Z'

  localparam logic [RADIX_W-1:0] DIGIT_MAX_DEC = 6'd9;

  // 'A' stands for digit ten.
  localparam logic [CHAR_W-1:0] CHAR_ALPHA_BASE = CHAR_A - 7'd10;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    if (d > DIGIT_MAX_DEC) begin
      return CHAR_ALPHA_BASE + CHAR_W'(d);
    end
    return CHAR_ZERO + CHAR_W'(d);
  endfunction

endpackage

[hdl/itoa_front.sv]
// ---------------------------------------------------------------------------
// itoa_front
// Accepts a command, splits it into sign and magnitude, clamps the radix.
// ---------------------------------------------------------------------------
module itoa_front
  import itoa_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                              start,
  output logic                              busy,
  input  logic [VALUE_BITS-1:0]             value,
  input  logic [RADIX_W-1:0]                radix,
  input  logic                              q_full,
  output logic                              push,
  output logic [VALUE_BITS+RADIX_W:0]       push_data
);

  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic [RADIX_W-1:0]    base;

  always_comb begin
    neg = value[VALUE_BITS-1];
    // two's complement negate; the most negative value maps onto itself,
    // which is the right unsigned magnitude
    mag = neg ? (~value + 1'b1) : value;
    if (radix < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix;
    end
  end

  assign busy      = q_full;
  assign push      = start & ~q_full;
  assign push_data = {neg, base, mag};

endmodule

[hdl/itoa_queue.sv]
// ---------------------------------------------------------------------------
// itoa_queue
// Two-entry FIFO between the front end and the conversion engine.
// ---------------------------------------------------------------------------
module itoa_queue #(
  parameter int WIDTH = 39
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/itoa_back.sv]
// ---------------------------------------------------------------------------
// itoa_back
// Conversion engine: repeated division by the radix, four quotient bits per
// cycle, digits stored least significant first, then emitted in reverse.
// ---------------------------------------------------------------------------
module itoa_back
  import itoa_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  logic [VALUE_BITS+RADIX_W:0] q_data,
  output logic                        pop,
  output logic                        strobe,
  output logic [CHAR_W-1:0]           character,
  output logic                        last_char
);

  localparam int DIV_STEP   = 4;
  localparam int PAD_BITS   = ((VALUE_BITS + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
  localparam int DIV_CYCLES = PAD_BITS / DIV_STEP;
  localparam int SW         = $clog2(DIV_CYCLES);
  localparam int AW         = $clog2(VALUE_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_RD,
    S_OUT
  } state_t;

  state_t              state;
  logic [PAD_BITS-1:0] work;
  logic [RADIX_W-1:0]  base;
  logic                neg;
  logic [RADIX_W-1:0]  rem;
  logic [SW-1:0]       step;
  logic [AW:0]         cnt;       // digit count
  logic [AW:0]         cnt_inc;
  logic [AW-1:0]       idx;

  logic [RADIX_W-1:0]  mem [VALUE_BITS];
  logic [RADIX_W-1:0]  rd_data;

  logic [RADIX_W-1:0]  rem_next;
  logic [DIV_STEP-1:0] qbits;
  logic [PAD_BITS-1:0] quot;
  logic                last_step;
  logic                mem_we;

  // Four restoring divide steps on the narrow remainder.
  always_comb begin
    logic [RADIX_W:0]   trial;
    logic [RADIX_W-1:0] r;
    r     = rem;
    qbits = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial = {r, work[PAD_BITS-1-i]};
      if (trial >= {1'b0, base}) begin
        trial              = trial - {1'b0, base};
        qbits[DIV_STEP-1-i] = 1'b1;
      end
      r = trial[RADIX_W-1:0];
    end
    rem_next = r;
  end

  assign quot      = {work[PAD_BITS-DIV_STEP-1:0], qbits};
  assign last_step = (step == SW'(DIV_CYCLES - 1));
  assign cnt_inc   = cnt + 1'b1;
  assign mem_we    = (state == S_DIV) && last_step;
  assign pop       = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt[AW-1:0]] <= rem_next;
    end
    rd_data <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      cnt    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          strobe <= 1'b0;
          if (q_valid) begin
            work  <= PAD_BITS'(q_data[VALUE_BITS-1:0]);
            base  <= q_data[VALUE_BITS+RADIX_W-1:VALUE_BITS];
            neg   <= q_data[VALUE_BITS+RADIX_W];
            rem   <= '0;
            step  <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          strobe <= 1'b0;
          work   <= quot;
          if (last_step) begin
            rem  <= '0;
            step <= '0;
            cnt  <= cnt_inc;
            if ((quot == '0) || (cnt_inc == (AW+1)'(VALUE_BITS))) begin
              idx   <= cnt[AW-1:0];
              state <= neg ? S_SIGN : S_RD;
            end
          end else begin
            rem  <= rem_next;
            step <= step + 1'b1;
          end
        end
        S_SIGN: begin
          strobe    <= 1'b1;
          character <= CHAR_MINUS;
          last_char <= 1'b0;
          state     <= S_RD;
        end
        S_RD: begin
          strobe <= 1'b0;
          state  <= S_OUT;
        end
        S_OUT: begin
          strobe    <= 1'b1;
          character <= digit_char(rd_data);
          last_char <= (idx == '0);
          if (idx == '0) begin
            state <= S_IDLE;
          end else begin
            idx   <= idx - 1'b1;
            state <= S_RD;
          end
        end
        default: begin
          strobe <= 1'b0;
          state  <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/integer_to_ascii_radix_converter_unit.sv]
// ---------------------------------------------------------------------------
// integer_to_ascii_radix_converter_unit
// Converts a signed integer to its ASCII text in a programmable radix,
// one character per beat, most significant character first.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake              Payload                  Notes
//  --------  ---------------------  -----------------------  ----------------
//  command   start & !busy          value                    one integer/beat
//  result    strobe (1 cycle)       character, last_char     no back-pressure
//  config    psel&penable&pwrite    paddr, pwdata, prdata    radix at 0x0
//
//  Flow: each digit comes out of the shared divider (4 quotient bits per
//  cycle), and each character is then read back from the digit store and
//  driven out; a minus sign, when present, is driven before the digits.
//  Reset: rst is synchronous; radix returns to 10, the queue and engine idle.
//  Stalls: busy rises only when the two-entry queue is full; the result side
//  cannot be stalled, so every character is shown for exactly one cycle.
// ---------------------------------------------------------------------------
module integer_to_ascii_radix_converter_unit
  import itoa_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // command
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] value,
  // result
  output logic                  strobe,
  output logic [CHAR_W-1:0]     character,
  output logic                  last_char,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int JOB_W = VALUE_BITS + RADIX_W + 1;

  logic [RADIX_W-1:0] radix;
  logic               cfg_wr;

  logic               q_full;
  logic               q_push;
  logic [JOB_W-1:0]   q_push_data;
  logic               q_pop;
  logic               q_valid;
  logic [JOB_W-1:0]   q_pop_data;

  // Config: one register, selected by word index (paddr bit 2).
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_RADIX);
  assign prdata = (paddr[2] == REG_RADIX) ? 32'(radix) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_wr) begin
      radix <= pwdata[RADIX_W-1:0];
    end
  end

  // Front end: take the beat, split sign and magnitude, clamp the radix.
  itoa_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .start     (start),
    .busy      (busy),
    .value     (value),
    .radix     (radix),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  // Hold up to two classified jobs while the engine works.
  itoa_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_pop_data)
  );

  // Engine: divide down to digits, then drive characters out in order.
  itoa_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_pop_data),
    .pop       (q_pop),
    .strobe    (strobe),
    .character (character),
    .last_char (last_char)
  );

endmodule

[hdl/itoa_checker.sv]
// ---------------------------------------------------------------------------
// itoa_checker
// Port-level checks of the converter's result stream, bound to the top.
// ---------------------------------------------------------------------------
`include "integer_to_ascii_radix_converter_unit_assert.svh"

module itoa_checker
  import itoa_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              strobe,
  input logic [CHAR_W-1:0] character,
  input logic              last_char
);

  // Only '-', digits and capitals ever leave the block.
  `ITOA_ASSERT_SAME(a_char_legal, strobe, (character == CHAR_MINUS) || ((character >= CHAR_ZERO) && (character <= CHAR_NINE)) || ((character >= CHAR_A) && (character <= CHAR_Z)))

  // A minus sign is never the end of a number.
  `ITOA_ASSERT_SAME(a_minus_not_last, strobe && (character == CHAR_MINUS), !last_char)

  // Each character is read back from the store, so beats never touch.
  `ITOA_ASSERT_NEXT(a_beat_gap, strobe, !strobe)

  // No result beat in the cycle after reset.
  `ITOA_ASSERT_RESET(a_reset_quiet, rst, !strobe)

endmodule

bind integer_to_ascii_radix_converter_unit itoa_checker u_itoa_checker (
  .clk       (clk),
  .rst       (rst),
  .strobe    (strobe),
  .character (character),
  .last_char (last_char)
);

[sim/integer_to_ascii_radix_converter_unit_test.sv]
// ---------------------------------------------------------------------------
// Integer-to-ASCII radix converter testbench
// Drives signed integers into the converter over the start/busy command port
// and predicts the character beats that each one must produce. It compares
// every strobed beat with the oldest prediction and reprograms the radix over
// APB between phases. Radix settings include values below two and above
// thirty-six, which the block clamps.
// ---------------------------------------------------------------------------
module integer_to_ascii_radix_converter_unit_test
  import itoa_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_W      = 32;
  // Pause this long after the last pending beat before touching radix.
  localparam int DRAIN_CYCLES = 400;
  // Quiet cycles allowed: longest sender gap plus one full item, several times.
  localparam int QUIET_LIMIT  = 5000;
  localparam int MAX_GAP      = 350;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 40;
  localparam logic [2:0] RADIX_ADDR = {REG_RADIX, 2'b00};

  // -------------------------------------------------------------------------
  // Scoreboard: spells each accepted integer into its character beats and
  // checks strobed beats against them in order.
  // -------------------------------------------------------------------------
  class text_scoreboard;
    typedef struct {
      logic [CHAR_W-1:0] code;
      logic              last;
    } char_beat_t;

    char_beat_t         pending_chars[$];
    logic [RADIX_W-1:0] radix_reg;
    int unsigned        failures;

    function new();
      radix_reg = RADIX_RESET;
      failures  = 0;
    endfunction

    function void set_radix(logic [31:0] data);
      radix_reg = data[RADIX_W-1:0];
    endfunction

    function int unsigned pending();
      return pending_chars.size();
    endfunction

    // Spell one accepted integer: sign first, then digits most significant first.
    function void note_value(logic [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] mag;
      logic [RADIX_W-1:0] base;
      logic [RADIX_W-1:0] digits[$];
      char_beat_t         beat;
      int                 i;
      if (radix_reg < RADIX_MIN) begin
        base = RADIX_MIN;
      end else if (radix_reg > RADIX_MAX) begin
        base = RADIX_MAX;
      end else begin
        base = radix_reg;
      end
      // Unsigned magnitude, so the most negative value converts cleanly.
      mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
      do begin
        digits.push_back(RADIX_W'(mag % base));
        mag = mag / base;
      end while (mag != 0);
      if (v[VALUE_W-1]) begin
        beat.code = CHAR_MINUS;
        beat.last = 1'b0;
        pending_chars.push_back(beat);
      end
      for (i = digits.size() - 1; i >= 0; i--) begin
        if (digits[i] > DIGIT_MAX_DEC) begin
          beat.code = CHAR_A + CHAR_W'(digits[i] - DIGIT_MAX_DEC - 6'd1);
        end else begin
          beat.code = CHAR_ZERO + CHAR_W'(digits[i]);
        end
        beat.last = (i == 0);
        pending_chars.push_back(beat);
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] code, logic last);
      char_beat_t want;
      if (pending_chars.size() == 0) begin
        $error("character: no beat pending, got %h (last_char %b)", code, last);
        failures++;
        return;
      end
      want = pending_chars.pop_front();
      if (code !== want.code) begin
        $error("character: expected %h, got %h", want.code, code);
        failures++;
      end
      if (last !== want.last) begin
        $error("last_char: expected %b, got %b", want.last, last);
        failures++;
      end
    endfunction

    function void check_drained();
      if (pending_chars.size() != 0) begin
        $error("character: %0d beats never arrived", pending_chars.size());
        failures++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic [VALUE_W-1:0]  value;
  logic                strobe;
  logic [CHAR_W-1:0]   character;
  logic                last_char;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  text_scoreboard      text_sb;
  int unsigned         idle_pct;
  int unsigned         quiet_cycles;

  integer_to_ascii_radix_converter_unit #(
    .VALUE_BITS(VALUE_W)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .strobe    (strobe),
    .character (character),
    .last_char (last_char),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Monitor: sample both channels on the edge, before any driver update lands.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        text_sb.note_value(value);
      end
      if (strobe) begin
        text_sb.check_char(character, last_char);
      end
    end
  end

  // Watchdog: count edges with no command beat, no character beat and no
  // register access; give up when the block has gone silent too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Send one integer. Hold start high across back-to-back beats; drop it only
  // when an idle gap is taken, so start gets one update per edge.
  task automatic send_value(input logic [VALUE_W-1:0] v);
    int unsigned gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(3) == 0 ? $urandom_range(MAX_GAP, 1) : $urandom_range(4, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
  endtask

  // Drop start, wait out every pending beat, then let the engine settle.
  task automatic drain();
    start <= 1'b0;
    while (text_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup then access cycle; the write lands on the edge that sees pready.
  task automatic write_radix(input logic [RADIX_W-1:0] r);
    logic [31:0] data;
    // Random upper bits: the register must keep only its low six.
    data = $urandom;
    data[RADIX_W-1:0] = r;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RADIX_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    text_sb.set_radix(data);
  endtask

  // Mix of full-range words, short magnitudes, extremes and powers of two.
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        v = $urandom;
      end
      4, 5: begin
        v = $urandom_range(1000);
        if ($urandom_range(1)) v = -v;
      end
      6: begin
        case ($urandom_range(3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = '0;
          default: v = '1;
        endcase
      end
      7: begin
        v = 32'h1 << $urandom_range(31);
        if ($urandom_range(1)) v = -v;
      end
      8: begin
        v = (32'h1 << $urandom_range(31)) - 1;
      end
      default: begin
        v = $urandom >> $urandom_range(31);
      end
    endcase
    return v;
  endfunction

  initial begin
    logic [RADIX_W-1:0] phase_radix[PHASES];
    int unsigned        phase_idle[3];
    int                 p;
    int                 n;
    phase_radix = '{6'd16, 6'd2, 6'd36, 6'd10, 6'd37, 6'd1, 6'd7, 6'd0};
    phase_idle  = '{0, 54, 32};
    text_sb  = new();
    idle_pct = 0;
    rst      = 1'b1;
    start    = 1'b0;
    value    = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset radix first, zero, both extremes, digit boundaries.
    send_value(32'd0);
    send_value(32'd1);
    send_value(-32'sd1);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'd9);
    send_value(32'd10);
    send_value(-32'sd123456789);
    drain();
    // Top radix: the letter 'Z', the carry past it, and the longest negative text.
    write_radix(RADIX_MAX);
    send_value(32'd35);
    send_value(32'd36);
    send_value(-32'sd1295);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    drain();
    // Binary: thirty-two digits plus the minus on the most negative value.
    write_radix(RADIX_MIN);
    send_value(32'd0);
    send_value(32'h8000_0000);
    send_value(-32'sd1);
    send_value(32'h7FFF_FFFF);
    drain();
    // Clamped settings: zero and one act as two, above 36 acts as 36.
    write_radix(6'd0);
    send_value(32'd5);
    send_value(-32'sd5);
    drain();
    write_radix(6'd63);
    send_value(32'd35);
    send_value(-32'sd71);
    drain();
    write_radix(6'd1);
    send_value(32'd3);
    drain();
    write_radix(6'd37);
    send_value(32'd36);
    drain();

    // Random phases: advance through radix settings and sender idle rates.
    for (p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) begin
        phase_radix[p] = RADIX_W'($urandom_range(63));
      end
      write_radix(phase_radix[p]);
      idle_pct = phase_idle[p % 3];
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_value(pick_value());
      end
      idle_pct = 0;
      drain();
    end

    text_sb.check_drained();
    if (text_sb.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
